// ----- rtl/cme_pkg.sv -----
// Package for the counter machine execute block: item codes, command record,
// status codes and shared helpers. No dependencies.
package cme_pkg;

    // Fixed sizes of the stream fields
    localparam int VALUE_BITS  = 32;
    localparam int LINE_W      = 11;
    localparam int ARG_W       = 10;
    localparam int MAX_LINES   = 1024;
    localparam int NUM_REGS    = 32;
    localparam int RIDX_W      = 8;     // enough for the largest register file
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 48;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Request operation (tuser)
    typedef enum logic [1:0] {
        OP_PRESET  = 2'd0,
        OP_EXEC    = 2'd1,
        OP_RESTART = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    // Instruction opcodes
    typedef enum logic [2:0] {
        OPC_INC     = 3'd0,
        OPC_DEC     = 3'd1,
        OPC_ISZ     = 3'd2,
        OPC_JMP     = 3'd3,
        OPC_STP     = 3'd4,
        OPC_COMMENT = 3'd5,
        OPC_UNKNOWN = 3'd6
    } t_opc;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_STOPPED = 3'd1,
        ST_BAD_REG = 3'd2,
        ST_BAD_JMP = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_LINEOUT = 3'd5,
        ST_HALTED  = 3'd6
    } t_status;

    // Config register indexes
    typedef enum logic [1:0] {
        CFG_ALLOW_NEG = 2'd0,
        CFG_REG_COUNT = 2'd1,
        CFG_PROG_LEN  = 2'd2
    } t_cfg_idx;

    // Classified command kinds
    typedef enum logic [3:0] {
        K_PRESET,
        K_BAD_PRESET,
        K_RESTART,
        K_UNUSED,
        K_INC,
        K_DEC,
        K_ISZ,
        K_JMP,
        K_BAD_REG,
        K_BAD_JMP,
        K_STOP,
        K_NOP,
        K_UNKNOWN
    } t_kind;

    typedef struct packed {
        logic                  allow_neg;
        logic [5:0]            reg_count;
        logic [LINE_W-1:0]     prog_len;
    } t_cfg;

    typedef struct packed {
        t_kind                 kind;
        logic [RIDX_W-1:0]     ridx;
        logic [LINE_W-1:0]     target;
        logic [VALUE_BITS-1:0] value;
    } t_cmd;

    // Program length clipped to the line space
    function automatic logic [LINE_W-1:0] eff_lines(input logic [LINE_W-1:0] plen);
        logic [LINE_W-1:0] lim;
        lim = LINE_W'(MAX_LINES);
        return (plen < lim) ? plen : lim;
    endfunction

endpackage

// ----- rtl/cme_front.sv -----
// Front end: accepts requests and classifies them against the config
// (register and jump range checks). Depends on cme_pkg.
module cme_front #(
    parameter int NUM_REGS = cme_pkg::NUM_REGS
) (
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [cme_pkg::IN_DATA_W-1:0]  i_tdata,
    input  logic [1:0]                     i_tuser,
    input  cme_pkg::t_cfg                  i_cfg,
    input  logic                           i_q_ready,
    output logic                           o_push,
    output cme_pkg::t_cmd                  o_cmd
);
    import cme_pkg::*;

    t_op               op;
    t_opc              opc;
    logic [ARG_W-1:0]  arg;
    logic              reg_ok;
    logic              jmp_ok;
    logic [ARG_W-1:0]  arg_m1;

    assign o_tready = i_q_ready;
    assign o_push   = i_tvalid & i_q_ready;

    // Field unpack
    assign op     = t_op'(i_tuser);
    assign opc    = t_opc'(i_tdata[2:0]);
    assign arg    = i_tdata[12:3];
    assign arg_m1 = arg - ARG_W'(1);

    // Range checks: register 1..min(count, NUM_REGS), jump 1..eff lines
    assign reg_ok = (arg != '0) && (arg <= ARG_W'(i_cfg.reg_count))
                    && (arg <= ARG_W'(NUM_REGS));
    assign jmp_ok = (arg != '0) && ({1'b0, arg} <= eff_lines(i_cfg.prog_len));

    // Classification
    always_comb begin
        o_cmd.ridx   = reg_ok ? RIDX_W'(arg_m1) : '0;
        o_cmd.target = LINE_W'(arg_m1);
        o_cmd.value  = i_tdata[44:13];
        o_cmd.kind   = K_UNUSED;
        case (op)
            OP_PRESET:  o_cmd.kind = reg_ok ? K_PRESET : K_BAD_PRESET;
            OP_RESTART: o_cmd.kind = K_RESTART;
            OP_EXEC: begin
                case (opc)
                    OPC_INC:     o_cmd.kind = reg_ok ? K_INC : K_BAD_REG;
                    OPC_DEC:     o_cmd.kind = reg_ok ? K_DEC : K_BAD_REG;
                    OPC_ISZ:     o_cmd.kind = reg_ok ? K_ISZ : K_BAD_REG;
                    OPC_JMP:     o_cmd.kind = jmp_ok ? K_JMP : K_BAD_JMP;
                    OPC_STP:     o_cmd.kind = K_STOP;
                    OPC_COMMENT: o_cmd.kind = K_NOP;
                    default:     o_cmd.kind = K_UNKNOWN;
                endcase
            end
            default:    o_cmd.kind = K_UNUSED;
        endcase
    end

endmodule

// ----- rtl/cme_queue.sv -----
// Short command queue between front and back ends.
// Depends on cme_pkg.
module cme_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cme_pkg::t_cmd  i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output cme_pkg::t_cmd  o_cmd
);
    import cme_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_count;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count over depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
        else $error("queue count not advanced on push");
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/cme_back.sv -----
// Back end: executes classified commands against the register file and the
// line counter, and holds the result register. Depends on cme_pkg.
module cme_back #(
    parameter int NUM_REGS = cme_pkg::NUM_REGS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cme_pkg::t_cfg                      i_cfg,
    input  logic                               i_q_valid,
    input  cme_pkg::t_cmd                      i_cmd,
    output logic                               o_pop,
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [cme_pkg::OUT_DATA_W-1:0]     o_tdata
);
    import cme_pkg::*;

    localparam int RI_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [VALUE_BITS-1:0]  r_regs [NUM_REGS];
    logic [LINE_W-1:0]      r_line;
    logic                   r_halted;
    logic                   r_out_valid;
    t_status                r_status;
    logic [LINE_W-1:0]      r_out_line;
    logic [VALUE_BITS-1:0]  r_value;

    logic [RI_W-1:0]        ri;
    logic [VALUE_BITS-1:0]  cur;
    logic [VALUE_BITS-1:0]  dec_v;
    logic                   wr_en;
    logic [VALUE_BITS-1:0]  wr_val;
    t_status                n_status;
    logic [LINE_W-1:0]      n_line;
    logic                   n_halted;
    logic [VALUE_BITS-1:0]  n_value;
    logic [LINE_W-1:0]      nl;
    logic                   moves;
    logic                   is_exec;

    assign ri    = i_cmd.ridx[RI_W-1:0];
    assign cur   = r_regs[ri];
    assign dec_v = cur - VALUE_BITS'(1);
    assign o_pop = i_q_valid && (!r_out_valid || i_tready);

    // Execute one command
    always_comb begin
        wr_en    = 1'b0;
        wr_val   = '0;
        n_status = ST_OK;
        n_line   = r_line;
        n_halted = r_halted;
        n_value  = '0;
        nl       = r_line;
        moves    = 1'b0;
        is_exec  = 1'b0;
        case (i_cmd.kind)
            K_PRESET: begin
                wr_en   = 1'b1;
                wr_val  = i_cmd.value;
                n_value = i_cmd.value;
            end
            K_BAD_PRESET: n_status = ST_BAD_REG;
            K_RESTART: begin
                n_line   = '0;
                n_halted = 1'b0;
            end
            K_UNUSED: n_status = ST_UNKNOWN;
            default: is_exec = 1'b1;
        endcase
        if (is_exec) begin
            if (r_halted) begin
                n_status = ST_HALTED;
            end else begin
                case (i_cmd.kind)
                    K_INC: begin
                        wr_en   = 1'b1;
                        wr_val  = cur + VALUE_BITS'(1);
                        n_value = wr_val;
                        nl      = r_line + LINE_W'(1);
                        moves   = 1'b1;
                    end
                    K_DEC: begin
                        wr_en   = 1'b1;
                        wr_val  = (dec_v[VALUE_BITS-1] && !i_cfg.allow_neg) ? '0 : dec_v;
                        n_value = wr_val;
                        nl      = r_line + LINE_W'(1);
                        moves   = 1'b1;
                    end
                    K_ISZ: begin
                        n_value = cur;
                        nl      = r_line + ((cur == '0) ? LINE_W'(2) : LINE_W'(1));
                        moves   = 1'b1;
                    end
                    K_JMP: begin
                        nl    = i_cmd.target;
                        moves = 1'b1;
                    end
                    K_NOP: begin
                        nl    = r_line + LINE_W'(1);
                        moves = 1'b1;
                    end
                    K_BAD_REG: n_status = ST_BAD_REG;
                    K_BAD_JMP: n_status = ST_BAD_JMP;
                    K_STOP:    n_status = ST_STOPPED;
                    default:   n_status = ST_UNKNOWN;
                endcase
                if (moves) begin
                    n_line = nl;
                    if (nl >= eff_lines(i_cfg.prog_len)) begin
                        n_status = ST_LINEOUT;
                    end
                end
                if (n_status != ST_OK) begin
                    n_halted = 1'b1;
                end
            end
        end
    end

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (o_pop && wr_en) begin
            r_regs[ri] <= wr_val;
        end
    end

    // Line counter and halt flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= '0;
            r_halted <= 1'b0;
        end else if (o_pop) begin
            r_line   <= n_line;
            r_halted <= n_halted;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status   <= n_status;
            r_out_line <= n_line;
            r_value    <= n_value;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {(OUT_DATA_W - VALUE_BITS - LINE_W - 3)'(0),
                       r_value, r_out_line, r_status};

`ifndef SYNTHESIS
    a_halted_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !r_halted) |-> (n_status != ST_HALTED))
        else $error("halted status without halt flag");
    a_lineout_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_status == ST_LINEOUT) |=> r_halted)
        else $error("line out did not halt");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == K_RESTART) |=> (r_line == '0 && !r_halted))
        else $error("restart did not clear line and halt");
`endif

endmodule

// ----- rtl/counter_machine_execute.sv -----
// Top level of the counter machine execute block: config registers, front
// end, command queue and back end. Depends on cme_pkg, cme_front, cme_queue,
// cme_back.
//
//   channel   | dir | handshake                    | content
//   ----------+-----+------------------------------+-------------------------------
//   s_axis    | in  | s_axis_tvalid/s_axis_tready  | one request (operation in tuser)
//   m_axis    | out | m_axis_tvalid/m_axis_tready  | one result per request
//   apb       | in  | psel & penable & pwrite      | allow_neg, reg_count, prog_len
//
// One request per clock unless the output stalls; a request is written to the queue,
// then one register read-modify-write in the back end registers its result.
// The register file write lands at the edge, so a following request reads it.
// Reset is synchronous: registers, line counter and halt flag clear at once.
// A stalled output holds the result register; the four-entry queue keeps the
// input side open until it fills.
module counter_machine_execute #(
    parameter int NUM_REGS = cme_pkg::NUM_REGS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] opcode, [12:3] operand, [44:13] preset_value, [47:45] zero
    input  logic [cme_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] status, [13:3] next_line, [45:14] register_value, [47:46] zero
    output logic [cme_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cme_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cme_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cme_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import cme_pkg::*;

    t_cfg      r_cfg;
    t_cfg_idx  cfg_idx;
    logic      cfg_wr;
    logic      q_ready;
    logic      q_valid;
    logic      push;
    logic      pop;
    t_cmd      front_cmd;
    t_cmd      head_cmd;

    // Config registers
    assign pready  = 1'b1;
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.allow_neg <= 1'b0;
            r_cfg.reg_count <= 6'd8;
            r_cfg.prog_len  <= LINE_W'(16);
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_ALLOW_NEG: r_cfg.allow_neg <= pwdata[0];
                CFG_REG_COUNT: r_cfg.reg_count <= pwdata[5:0];
                CFG_PROG_LEN:  r_cfg.prog_len  <= pwdata[LINE_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Config readback
    always_comb begin
        case (cfg_idx)
            CFG_ALLOW_NEG: prdata = APB_DATA_W'(r_cfg.allow_neg);
            CFG_REG_COUNT: prdata = APB_DATA_W'(r_cfg.reg_count);
            CFG_PROG_LEN:  prdata = APB_DATA_W'(r_cfg.prog_len);
            default:       prdata = '0;
        endcase
    end

    cme_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    cme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    cme_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// ----- bench/counter_machine_execute_tb.sv -----
// Testbench for counter_machine_execute: drives requests and config writes,
// predicts each result with a scoreboard class and checks every result field.
// Depends on cme_pkg and the counter_machine_execute RTL.
module counter_machine_execute_tb;
    import cme_pkg::*;

    localparam logic [2:0] OPC_RESERVED = 3'd7;   // second unknown opcode
    localparam int         CYCLE_LIMIT  = 400000;

    // Predicts results from its own copy of the registers, line and config
    class exec_scoreboard;
        typedef struct {
            logic [2:0]  status;
            logic [10:0] line;
            logic [31:0] value;
        } t_result;

        t_result     expected_q[$];
        logic [31:0] regs[NUM_REGS];
        logic [10:0] line;
        bit          halted;
        bit          allow_neg;
        logic [5:0]  reg_count;
        logic [10:0] prog_len;
        int          errors;
        int          checked;
        int          status_tally[8];

        function new();
            foreach (regs[i]) regs[i] = '0;
            line      = '0;
            halted    = 1'b0;
            allow_neg = 1'b0;
            reg_count = 6'd8;
            prog_len  = 11'd16;
            errors    = 0;
            checked   = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void set_config(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_ALLOW_NEG: allow_neg = value[0];
                CFG_REG_COUNT: reg_count = value[5:0];
                CFG_PROG_LEN:  prog_len  = value[10:0];
                default: ;
            endcase
        endfunction

        function int unsigned usable_regs();
            return (reg_count < NUM_REGS) ? reg_count : NUM_REGS;
        endfunction

        function int unsigned usable_lines();
            return (prog_len < MAX_LINES) ? prog_len : MAX_LINES;
        endfunction

        // Update the model for one accepted request and queue its result
        function void note_request(t_op op, logic [2:0] opc, logic [9:0] arg,
                                   logic [31:0] pv);
            t_result     r;
            bit          reg_ok;
            bit          moves;
            int unsigned ri;
            logic [10:0] nl;
            logic [31:0] v;
            r.status = ST_OK;
            r.value  = '0;
            reg_ok   = (arg >= 1) && (arg <= usable_regs());
            ri       = reg_ok ? arg - 1 : 0;
            case (op)
                OP_PRESET: begin
                    if (reg_ok) begin
                        regs[ri] = pv;
                        r.value  = pv;
                    end else begin
                        r.status = ST_BAD_REG;
                    end
                end
                OP_RESTART: begin
                    line   = '0;
                    halted = 1'b0;
                end
                OP_UNUSED: r.status = ST_UNKNOWN;
                default: begin
                    if (halted) begin
                        r.status = ST_HALTED;
                    end else begin
                        nl    = line;
                        moves = 1'b0;
                        if (opc <= OPC_ISZ && !reg_ok) begin
                            r.status = ST_BAD_REG;
                        end else begin
                            case (opc)
                                OPC_INC: begin
                                    regs[ri] = regs[ri] + 32'd1;
                                    r.value  = regs[ri];
                                    nl       = line + 11'd1;
                                    moves    = 1'b1;
                                end
                                OPC_DEC: begin
                                    v = regs[ri] - 32'd1;
                                    // clamp at zero unless negatives are allowed
                                    if (v[31] && !allow_neg) v = '0;
                                    regs[ri] = v;
                                    r.value  = v;
                                    nl       = line + 11'd1;
                                    moves    = 1'b1;
                                end
                                OPC_ISZ: begin
                                    r.value = regs[ri];
                                    nl      = line + ((r.value == 0) ? 11'd2 : 11'd1);
                                    moves   = 1'b1;
                                end
                                OPC_JMP: begin
                                    if (arg >= 1 && arg <= usable_lines()) begin
                                        nl    = 11'(arg - 1);
                                        moves = 1'b1;
                                    end else begin
                                        r.status = ST_BAD_JMP;
                                    end
                                end
                                OPC_STP: r.status = ST_STOPPED;
                                OPC_COMMENT: begin
                                    nl    = line + 11'd1;
                                    moves = 1'b1;
                                end
                                default: r.status = ST_UNKNOWN;
                            endcase
                        end
                        if (moves) begin
                            line = nl;
                            if (nl >= usable_lines()) r.status = ST_LINEOUT;
                        end
                        if (r.status != ST_OK) halted = 1'b1;
                    end
                end
            endcase
            r.line = line;
            expected_q = {expected_q, r};
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(logic [47:0] d);
            t_result r;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: tdata %h", d);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            status_tally[d[2:0]]++;
            if (d[2:0] !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, d[2:0]);
                errors++;
            end
            if (d[13:3] !== r.line) begin
                $error("next_line: expected %0d, got %0d", r.line, d[13:3]);
                errors++;
            end
            if (d[45:14] !== r.value) begin
                $error("register_value: expected %h, got %h", r.value, d[45:14]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [2:0] opcode, [12:3] operand, [44:13] preset_value, [47:45] zero
    logic [47:0] s_axis_tdata;
    // [1:0] operation
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [2:0] status, [13:3] next_line, [45:14] register_value, [47:46] zero
    logic [47:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    exec_scoreboard sb;
    int idle_pct   = 0;
    int stall_left = 0;
    int cycles     = 0;
    int requests   = 0;
    int settings   = 0;

    counter_machine_execute i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stall bursts on tready
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** counter_machine_execute: FAILED **");
            $finish;
        end
    end

    // One request; returns at the edge where it is accepted
    task automatic send_request(t_op op, logic [2:0] opc, logic [9:0] arg,
                                logic [31:0] pv);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pv, arg, opc};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, opc, arg, pv);
        requests++;
    endtask

    // APB write: setup phase, then access phase, then the bus goes idle
    task automatic cfg_write(t_cfg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_config(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and wait until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return 32'($urandom_range(0, 2));
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed program steps, restarts after a halt, some noise
    task automatic issue_random_request();
        int unsigned pick;
        int unsigned nregs;
        int unsigned nlines;
        logic [9:0]  reg_arg;
        logic [9:0]  line_arg;
        pick   = $urandom_range(0, 99);
        nregs  = sb.usable_regs();
        nlines = (sb.usable_lines() > 1023) ? 1023 : sb.usable_lines();
        reg_arg = (nregs == 0) ? 10'($urandom_range(0, 1023))
                               : 10'($urandom_range(1, nregs));
        line_arg = (nlines == 0 || $urandom_range(0, 9) == 0)
                 ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(1, nlines));
        if (sb.halted && pick < 85) begin
            send_request(OP_RESTART, 3'($urandom_range(0, 7)),
                         10'($urandom_range(0, 1023)), $urandom);
        end else if (pick < 10) begin
            send_request(OP_PRESET, 3'($urandom_range(0, 7)), reg_arg, pick_value());
        end else if (pick < 15) begin
            send_request(t_op'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         10'($urandom_range(0, 1023)), $urandom);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 26)      send_request(OP_EXEC, OPC_INC, reg_arg, $urandom);
            else if (pick < 50) send_request(OP_EXEC, OPC_DEC, reg_arg, $urandom);
            else if (pick < 68) send_request(OP_EXEC, OPC_ISZ, reg_arg, $urandom);
            else if (pick < 80) send_request(OP_EXEC, OPC_JMP, line_arg, $urandom);
            else if (pick < 90) send_request(OP_EXEC, OPC_COMMENT, reg_arg, $urandom);
            else if (pick < 93) send_request(OP_EXEC, OPC_STP, reg_arg, $urandom);
            else if (pick < 96)
                send_request(OP_EXEC, pick[0] ? OPC_UNKNOWN : OPC_RESERVED,
                             reg_arg, $urandom);
            else
                send_request(OP_EXEC, 3'($urandom_range(0, 2)),
                             10'($urandom_range(0, 1023)), $urandom);
        end
    endtask

    // New register setting, then a block of random requests
    task automatic run_setting(bit neg, int rcount, int plen, int count, int idle);
        drain();
        cfg_write(CFG_ALLOW_NEG, 32'(neg));
        cfg_write(CFG_REG_COUNT, 32'(rcount));
        cfg_write(CFG_PROG_LEN, 32'(plen));
        settings++;
        idle_pct = idle;
        repeat (count) issue_random_request();
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed steps under the reset setting (8 registers, 16 lines)
        idle_pct = 20;
        settings = 1;
        send_request(OP_EXEC, OPC_INC, 10'd1, '0);
        send_request(OP_PRESET, OPC_INC, 10'd8, 32'h7FFF_FFFF);
        send_request(OP_EXEC, OPC_INC, 10'd8, '0);          // wraps to most negative
        send_request(OP_EXEC, OPC_DEC, 10'd8, '0);          // most negative wraps back
        send_request(OP_EXEC, OPC_DEC, 10'd3, '0);          // clamps at zero
        send_request(OP_EXEC, OPC_ISZ, 10'd3, '0);          // zero: skip a line
        send_request(OP_EXEC, OPC_COMMENT, 10'd0, '0);
        send_request(OP_EXEC, OPC_JMP, 10'd16, '0);         // last line
        send_request(OP_EXEC, OPC_INC, 10'd1, '0);          // runs off the program
        send_request(OP_EXEC, OPC_INC, 10'd1, '0);          // ignored while halted
        send_request(OP_PRESET, OPC_INC, 10'd4, 32'hFFFF_FFFF);
        send_request(OP_RESTART, OPC_INC, 10'd0, '0);
        send_request(OP_EXEC, OPC_INC, 10'd0, '0);          // register zero is invalid
        send_request(OP_RESTART, OPC_INC, 10'd0, '0);
        send_request(OP_EXEC, OPC_JMP, 10'd0, '0);          // jump target zero
        send_request(OP_RESTART, OPC_INC, 10'd0, '0);
        send_request(OP_EXEC, OPC_UNKNOWN, 10'd1, '0);
        send_request(OP_RESTART, OPC_INC, 10'd0, '0);
        send_request(OP_EXEC, OPC_RESERVED, 10'd1, '0);
        send_request(OP_RESTART, OPC_INC, 10'd0, '0);
        send_request(OP_UNUSED, OPC_INC, 10'd1, 32'hFFFF_FFFF);
        send_request(OP_PRESET, OPC_INC, 10'd9, 32'h1234_5678);
        send_request(OP_PRESET, OPC_INC, 10'd1023, 32'hFFFF_FFFF);
        send_request(OP_EXEC, OPC_STP, 10'd1, '0);
        send_request(OP_RESTART, OPC_INC, 10'd0, '0);

        // Random blocks over several settings, extremes included
        run_setting(1'b1, 32, 1024, 300, 30);
        run_setting(1'b0, 1, 1, 150, 50);
        run_setting(1'b1, 63, 2047, 250, 20);
        run_setting(1'b0, 0, 0, 80, 30);
        run_setting(1'b1, 5, 40, 300, 0);
        run_setting(1'b0, 20, 300, 300, 40);
        run_setting(1'b1, 32, 12, 170, 0);

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d requests across %0d register settings, %0d results checked.",
                 requests, settings, sb.checked);
        $display("By status: ok %0d stp %0d reg %0d jmp %0d unk %0d out %0d halt %0d",
                 sb.status_tally[ST_OK], sb.status_tally[ST_STOPPED],
                 sb.status_tally[ST_BAD_REG], sb.status_tally[ST_BAD_JMP],
                 sb.status_tally[ST_UNKNOWN], sb.status_tally[ST_LINEOUT],
                 sb.status_tally[ST_HALTED]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** counter_machine_execute: PASSED **");
        end else begin
            $display("** counter_machine_execute: FAILED **");
        end
        $finish;
    end

endmodule
